// ===== hw/rtl/iqd_pkg.sv =====
// ----------------------------------------------------------------------------
// iqd_pkg
// Shared types, widths and helpers of the I/Q demodulator.
// ----------------------------------------------------------------------------
package iqd_pkg;

  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned PhaseBitsDef    = 32;
  localparam int unsigned CordicStagesDef = 16;

  localparam int unsigned XW = 36;
  localparam int unsigned ZW = 36;
  localparam int unsigned PW = 72;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStep   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOrigin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMatrix = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAmp    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegAux    = 3'd6;

  localparam logic [1:0] ModeIq   = 2'd0;
  localparam logic [1:0] ModePhase = 2'd1;
  localparam logic [1:0] ModeFreq = 2'd2;

  typedef struct packed {
    logic                 vld;
    logic                 rot;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cdc_t;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10680862;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // round half up then floor shift
  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                  input int unsigned s);
    logic signed [PW-1:0] h;
    h = '0;
    h[s-1] = 1'b1;
    return (v + h) >>> s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    logic [31:0] r;
    if (v > $signed(72'sd2147483647)) begin
      r = 32'h7fff_ffff;
    end else if (v < -$signed(72'sd2147483648)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/iqd_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// iqd_cordic_cell
// One micro-rotation of the cordic row, rotation or vectoring per item.
// ----------------------------------------------------------------------------
module iqd_cordic_cell import iqd_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cdc_t cell_i,
  output cdc_t cell_o
);

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] a;
  logic                 sigma;
  cdc_t                 cell_d, cell_q;

  assign xs    = cell_i.x >>> Idx;
  assign ys    = cell_i.y >>> Idx;
  assign a     = $signed({{(ZW-32){1'b0}}, atan_turn(Idx)});
  assign sigma = cell_i.rot ? !cell_i.z[ZW-1] : cell_i.y[XW-1];

  always_comb begin
    cell_d     = cell_i;
    if (sigma) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - a;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/iqd_cordic_chain.sv =====
// ----------------------------------------------------------------------------
// iqd_cordic_chain
// Row of cordic cells, one micro-rotation per cell and per cycle.
// ----------------------------------------------------------------------------
module iqd_cordic_chain import iqd_pkg::*; #(
  parameter int unsigned Stages = CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cdc_t chain_i,
  output cdc_t chain_o
);

  cdc_t              link [Stages+1];
  logic [Stages-1:0] vld_map;

  assign link[0] = chain_i;

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    iqd_cordic_cell #(.Idx(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
    assign vld_map[g] = link[g+1].vld;
  end

  assign chain_o = link[Stages];

  // a single item travels the row at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(vld_map))
    else $error("more than one item in cordic row");

  a_no_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_i.vld |-> vld_map == '0))
    else $error("launch into busy cordic row");

endmodule

// ===== hw/rtl/iq_demodulator_phase_freq.sv =====
// ----------------------------------------------------------------------------
// iq_demodulator_phase_freq
// NCO mixer, origin offset, correction matrix, then corrected I/Q or cordic based
// amplitude with unwrapped phase or frequency output, with saturation.
// ----------------------------------------------------------------------------
// channel   dir   handshake            payload
// s_axis    in    tvalid/tready        i_sample [SB-1:0], q_sample [2SB-1:SB]
// m_axis    out   tvalid/tready        first_out [31:0], second_out [63:32]
// cfg       in    cfg_we_i             cfg_index_i, cfg_data_i
//
// between one accept and the next, an item passes the cordic row twice (mixer
// rotation, vectoring), plus gain and offset, matrix, vectoring launch, scale
// and output load; the input takes no new item before that output load. the
// result waits in the output register while the next item is taken, which
// then holds and blocks the input until it drains
// reset is asynchronous and restores all registers to their defaults
// ----------------------------------------------------------------------------
module iq_demodulator_phase_freq import iqd_pkg::*; #(
  parameter int unsigned SampleBits   = SampleBitsDef,
  parameter int unsigned PhaseBits    = PhaseBitsDef,
  parameter int unsigned CordicStages = CordicStagesDef,
  localparam int unsigned DataW       = ((2*SampleBits+7)/8)*8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // i_sample, q_sample
  input  logic [DataW-1:0]   s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // first_out, second_out
  output logic [63:0]        m_axis_tdata_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_MAT, S_VLAUNCH, S_VEC, S_SCL, S_OUT
  } state_e;

  localparam logic signed [31:0] InvGain  = 32'sd652032874;
  localparam logic signed [ZW-1:0] Quarter = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] Half    = ZW'(64'sd2147483648);
  localparam logic [31:0] PhMask = ~32'd0 << (32 - PhaseBits);

  state_e state_q;
  logic [1:0]  mode_q;
  logic [31:0] step_q, origin_q, amp_sc_q, aux_sc_q, phase_q;
  logic [63:0] mat_q;
  logic signed [39:0] last_q;
  logic               have_q;
  logic signed [XW-1:0] x_q, y_q, amp_q;
  logic signed [31:0]   d_q;
  logic signed [39:0]   unwr_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic        out_vld_q;
  logic [63:0] out_q;

  cdc_t chain_in, chain_out;
  logic accept;

  logic signed [XW-1:0] xin, yin, xin_f, yin_f, oi, oq, vx, vy;
  logic signed [ZW-1:0] zr, zr_f, vz;
  logic signed [31:0]   zm;
  logic signed [PW-1:0] prx, pry, pmi, pmq, pamp, pr1, pr2;
  logic signed [40:0]   diff, u41, ur41;
  logic signed [31:0]   d_now;
  logic signed [39:0]   unwr_now;
  logic signed [32:0]   ur;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    xin = {{(XW-25){s_axis_tdata_i[SampleBits-1]}}, s_axis_tdata_i[SampleBits-1:0],
           {(25-SampleBits){1'b0}}};
    yin = {{(XW-25){s_axis_tdata_i[2*SampleBits-1]}},
           s_axis_tdata_i[2*SampleBits-1:SampleBits], {(25-SampleBits){1'b0}}};
    zm  = $signed(phase_q & PhMask);
    zr  = {{(ZW-32){zm[31]}}, zm};
    xin_f = xin;
    yin_f = yin;
    zr_f  = zr;
    if (zr > Quarter) begin
      xin_f = -xin;
      yin_f = -yin;
      zr_f  = zr - Half;
    end else if (zr < -Quarter) begin
      xin_f = -xin;
      yin_f = -yin;
      zr_f  = zr + Half;
    end
    vx = x_q;
    vy = y_q;
    vz = '0;
    if (x_q[XW-1]) begin
      vz = y_q[XW-1] ? -Half : Half;
      vx = -x_q;
      vy = -y_q;
    end
    chain_in.vld = accept || (state_q == S_VLAUNCH);
    chain_in.rot = (state_q == S_IDLE);
    chain_in.x   = (state_q == S_IDLE) ? xin_f : vx;
    chain_in.y   = (state_q == S_IDLE) ? yin_f : vy;
    chain_in.z   = (state_q == S_IDLE) ? zr_f : vz;
  end

  iqd_cordic_chain #(.Stages(CordicStages)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .chain_i (chain_in),
    .chain_o (chain_out)
  );

  always_comb begin
    oi   = {{(XW-25){origin_q[31]}}, origin_q[31:16], 9'b0};
    oq   = {{(XW-25){origin_q[15]}}, origin_q[15:0], 9'b0};
    prx  = chain_out.x * InvGain;
    pry  = chain_out.y * InvGain;
    pmi  = $signed(mat_q[63:48]) * x_q + $signed(mat_q[47:32]) * y_q;
    pmq  = $signed(mat_q[31:16]) * x_q + $signed(mat_q[15:0]) * y_q;
    pamp = chain_out.x * InvGain;
    diff = {{5{chain_out.z[ZW-1]}}, chain_out.z} - {last_q[39], last_q};
    d_now = have_q ? $signed(diff[31:0]) : 32'sd0;
    unwr_now = have_q ? 40'(last_q + {{8{d_now[31]}}, d_now})
                      : {{(40-ZW){chain_out.z[ZW-1]}}, chain_out.z};
    u41  = {unwr_q[39], unwr_q} + 41'sd128;
    ur41 = u41 >>> 8;
    ur   = ur41[32:0];
    case (mode_q)
      ModeIq: begin
        pr1 = $signed(amp_sc_q) * x_q;
        pr2 = $signed(amp_sc_q) * y_q;
      end
      ModePhase: begin
        pr1 = $signed(amp_sc_q) * amp_q;
        pr2 = $signed(aux_sc_q) * ur;
      end
      ModeFreq: begin
        pr1 = $signed(amp_sc_q) * amp_q;
        pr2 = $signed(aux_sc_q) * d_q;
      end
      default: begin
        pr1 = '0;
        pr2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= ModeIq;
      step_q    <= '0;
      phase_q   <= '0;
      origin_q  <= '0;
      mat_q     <= 64'h4000_0000_0000_4000;
      amp_sc_q  <= 32'd65536;
      aux_sc_q  <= 32'd262144;
      last_q    <= '0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      amp_q     <= '0;
      d_q       <= '0;
      unwr_q    <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
    end else begin
      if (state_q == S_OUT && (!out_vld_q || m_axis_tready_i)) begin
        out_q     <= {sat32(p2_q), sat32(p1_q)};
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMode:   mode_q   <= cfg_data_i[1:0];
          RegStep:   step_q   <= cfg_data_i[31:0];
          RegStart:  phase_q  <= cfg_data_i[31:0];
          RegOrigin: origin_q <= cfg_data_i[31:0];
          RegMatrix: mat_q    <= cfg_data_i;
          RegAmp:    amp_sc_q <= cfg_data_i[31:0];
          RegAux:    aux_sc_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            phase_q <= phase_q + step_q;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (chain_out.vld) begin
            x_q     <= XW'(rnd_sh(prx, 30)) + oi;
            y_q     <= XW'(rnd_sh(pry, 30)) + oq;
            state_q <= S_MAT;
          end
        end
        S_MAT: begin
          x_q     <= XW'(rnd_sh(pmi, 14));
          y_q     <= XW'(rnd_sh(pmq, 14));
          state_q <= S_VLAUNCH;
        end
        S_VLAUNCH: begin
          state_q <= S_VEC;
        end
        S_VEC: begin
          if (chain_out.vld) begin
            amp_q   <= XW'(rnd_sh(pamp, 30));
            d_q     <= d_now;
            unwr_q  <= unwr_now;
            last_q  <= unwr_now;
            have_q  <= 1'b1;
            state_q <= S_SCL;
          end
        end
        S_SCL: begin
          p1_q    <= rnd_sh(pr1, 24);
          p2_q    <= (mode_q == ModeFreq) ? rnd_sh(pr2, 32) : rnd_sh(pr2, 24);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  a_accept_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_ROT)
    else $error("accepted item did not start rotation");

  a_chain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.vld |-> (state_q == S_ROT || state_q == S_VEC))
    else $error("cordic result outside a waiting state");

  a_rot_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_out.vld && state_q == S_VEC) |-> !chain_out.rot)
    else $error("rotation result taken as vectoring");

endmodule

// ===== tb/sv/iq_demodulator_phase_freq_tb.sv =====
// ----------------------------------------------------------------------------
// iq_demodulator_phase_freq_tb
// Self-checking bench for the I/Q demodulator: a directed table covering
// sample extremes, every output mode, the first sample and the zero vector,
// then random configurations and samples and, in all but the last phase,
// random stalls on both stream sides, checked by a bit-true demodulator model.
// ----------------------------------------------------------------------------
module iq_demodulator_phase_freq_tb import iqd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeSpare = 2'd3;
  localparam longint     InvGain   = 64'sd652032874;
  localparam longint     HalfTurn  = 64'sd1 <<< 31;
  localparam longint     QtrTurn   = 64'sd1 <<< 30;
  localparam int         NStages   = 16;
  localparam int         NPhases   = 8;
  localparam int         PhaseLen  = 80;

  localparam longint AtanTurn [NStages] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  typedef struct {
    logic [1:0]          mode;
    logic signed [15:0]  i_s;
    logic signed [15:0]  q_s;
    bit                  typed;
    logic [31:0]         e_first;
    logic [31:0]         e_second;
  } dir_row_t;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
  } demod_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [31:0]        s_axis_tdata_i;   // i_sample, q_sample
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [63:0]        m_axis_tdata_o;   // first_out, second_out
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;

  iq_demodulator_phase_freq dut (.*);

  // model state and registers
  logic [1:0]  m_mode;
  logic [31:0] m_step, m_origin, m_amp, m_aux, m_nco;
  logic [63:0] m_matrix;
  longint      m_last;
  bit          m_have_last;

  demod_out_t  demod_q[$];
  int          n_err;
  bit          gaps_on;
  int          hold_cycles;

  dir_row_t dir_tab[] = '{
    '{ModeFreq,  16'sd0,      16'sd0,      1, 32'd0, 32'd0},
    '{ModeFreq,  16'sd32767,  16'sd0,      0, 32'd0, 32'd0},
    '{ModeFreq,  -16'sd32768, 16'sd0,      0, 32'd0, 32'd0},
    '{ModeFreq,  16'sd0,      16'sd32767,  0, 32'd0, 32'd0},
    '{ModeFreq,  16'sd0,      -16'sd32768, 0, 32'd0, 32'd0},
    '{ModeFreq,  -16'sd32768, -16'sd32768, 0, 32'd0, 32'd0},
    '{ModeIq,    16'sd0,      16'sd0,      1, 32'd0, 32'd0},
    '{ModeIq,    16'sd32767,  16'sd32767,  0, 32'd0, 32'd0},
    '{ModeIq,    -16'sd32768, 16'sd32767,  0, 32'd0, 32'd0},
    '{ModeIq,    16'sd1,      -16'sd1,     0, 32'd0, 32'd0},
    '{ModePhase, 16'sd32767,  16'sd0,      0, 32'd0, 32'd0},
    '{ModePhase, 16'sd0,      16'sd32767,  0, 32'd0, 32'd0},
    '{ModePhase, -16'sd32768, 16'sd0,      0, 32'd0, 32'd0},
    '{ModePhase, 16'sd0,      -16'sd32768, 0, 32'd0, 32'd0},
    '{ModePhase, 16'sd32767,  16'sd0,      0, 32'd0, 32'd0},
    '{ModePhase, -16'sd32768, -16'sd1,     0, 32'd0, 32'd0},
    '{ModePhase, 16'sd0,      16'sd0,      0, 32'd0, 32'd0},
    '{ModeSpare, 16'sd12345,  -16'sd222,   1, 32'd0, 32'd0},
    '{ModeSpare, -16'sd32768, 16'sd32767,  1, 32'd0, 32'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("iq_demodulator_phase_freq_tb: FAIL");
    $finish;
  end

  function automatic longint rnd_half(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void nco_rotate(inout longint x, inout longint y, input longint z);
    longint t;
    if (z > QtrTurn) begin
      x = -x; y = -y; z = z - HalfTurn;
    end else if (z < -QtrTurn) begin
      x = -x; y = -y; z = z + HalfTurn;
    end
    for (int k = 0; k < NStages; k++) begin
      if (z >= 0) begin
        t = x - (y >>> k); y = y + (x >>> k); z = z - AtanTurn[k];
      end else begin
        t = x + (y >>> k); y = y - (x >>> k); z = z + AtanTurn[k];
      end
      x = t;
    end
    x = rnd_half(x * InvGain, 30);
    y = rnd_half(y * InvGain, 30);
  endfunction

  function automatic void polar(input longint x, input longint y,
                                output longint mag, output longint ang);
    longint t;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x; y = -y;
    end
    for (int k = 0; k < NStages; k++) begin
      if (y >= 0) begin
        t = x + (y >>> k); y = y - (x >>> k); ang = ang + AtanTurn[k];
      end else begin
        t = x - (y >>> k); y = y + (x >>> k); ang = ang - AtanTurn[k];
      end
      x = t;
    end
    mag = rnd_half(x * InvGain, 30);
  endfunction

  function automatic demod_out_t demodulate(logic signed [15:0] si, logic signed [15:0] sq);
    demod_out_t r;
    longint x, y, i_now, q_now, amp, raw, d, unwr, as, xs, o1, o2;
    logic [31:0] d32;
    logic [39:0] u40;
    x = longint'(si) * 512;
    y = longint'(sq) * 512;
    nco_rotate(x, y, longint'($signed(m_nco)));
    m_nco = m_nco + m_step;
    x = x + longint'($signed(m_origin[31:16])) * 512;
    y = y + longint'($signed(m_origin[15:0])) * 512;
    i_now = rnd_half(longint'($signed(m_matrix[63:48])) * x +
                     longint'($signed(m_matrix[47:32])) * y, 14);
    q_now = rnd_half(longint'($signed(m_matrix[31:16])) * x +
                     longint'($signed(m_matrix[15:0])) * y, 14);
    polar(i_now, q_now, amp, raw);
    d = 0;
    if (m_have_last) begin
      d32 = raw[31:0] - m_last[31:0];
      d = longint'($signed(d32));
      u40 = m_last[39:0] + d[39:0];
    end else begin
      u40 = raw[39:0];
    end
    unwr = longint'($signed(u40));
    as = longint'($signed(m_amp));
    xs = longint'($signed(m_aux));
    o1 = 0;
    o2 = 0;
    case (m_mode)
      ModeIq: begin
        o1 = rnd_half(as * i_now, 24);
        o2 = rnd_half(as * q_now, 24);
      end
      ModePhase: begin
        o1 = rnd_half(as * amp, 24);
        o2 = rnd_half(xs * rnd_half(unwr, 8), 24);
      end
      ModeFreq: begin
        o1 = rnd_half(as * amp, 24);
        o2 = rnd_half(xs * d, 32);
      end
      default: ;
    endcase
    m_last = unwr;
    m_have_last = 1'b1;
    r.first = clip32(o1);
    r.second = clip32(o2);
    return r;
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMode:   m_mode = val[1:0];
      RegStep:   m_step = val[31:0];
      RegStart:  m_nco = val[31:0];
      RegOrigin: m_origin = val[31:0];
      RegMatrix: m_matrix = val;
      RegAmp:    m_amp = val[31:0];
      RegAux:    m_aux = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (demod_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq,
                             bit typed, demod_out_t want);
    demod_out_t p;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {sq, si};
    do @(posedge clk_i); while (!s_axis_tready_o);
    p = demodulate(si, sq);
    if (typed) p = want;
    demod_q = {demod_q, p};
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word(int pick);
    case (pick)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // result checker and output stall control
  initial begin
    int burst;
    demod_out_t e;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (demod_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected item %h", m_axis_tdata_o);
        end else begin
          e = demod_q.pop_front();
          if (m_axis_tdata_o[31:0] !== e.first || m_axis_tdata_o[63:32] !== e.second) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: expected first %h second %h, got first %h second %h",
                       e.first, e.second, m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    demod_out_t want;
    int pick;
    n_err = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegMode;
    cfg_data_i = '0;
    m_mode = ModeIq;
    m_step = '0;
    m_nco = '0;
    m_origin = '0;
    m_matrix = 64'h4000_0000_0000_4000;
    m_amp = 32'd65536;
    m_aux = 32'd262144;
    m_last = 0;
    m_have_last = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].mode != m_mode) begin
        s_axis_tvalid_i <= 1'b0;
        drain();
        cfg_write(RegMode, 64'(dir_tab[n].mode));
      end
      want.first = dir_tab[n].e_first;
      want.second = dir_tab[n].e_second;
      send_sample(dir_tab[n].i_s, dir_tab[n].q_s, dir_tab[n].typed, want);
    end

    for (int ph = 0; ph < NPhases; ph++) begin
      s_axis_tvalid_i <= 1'b0;
      drain();
      pick = (ph < 2) ? ph : 9;
      cfg_write(RegMode, 64'((ph < 4) ? ph : $urandom_range(0, 3)));
      cfg_write(RegStep, 64'(rand_word(pick)));
      cfg_write(RegStart, 64'(rand_word(pick == 0 ? 3 : pick)));
      cfg_write(RegOrigin, 64'(ph == 0 ? 32'h7fff_7fff : ph == 1 ? 32'h8000_8000 :
                               $urandom_range(0, 1) ? 32'h0 : $urandom));
      cfg_write(RegMatrix, ph == 0 ? 64'h7fff_7fff_7fff_7fff :
                           ph == 1 ? 64'h8000_8000_8000_8000 :
                           ph == 2 ? 64'h4000_0000_0000_4000 :
                           {$urandom, $urandom});
      cfg_write(RegAmp, 64'(rand_word(pick)));
      cfg_write(RegAux, 64'(rand_word(pick)));
      gaps_on = (ph != NPhases - 1);
      if (ph == 3) hold_cycles = 400;
      for (int n = 0; n < PhaseLen; n++)
        send_sample(rand_sample(), rand_sample(), 1'b0, want);
    end
    s_axis_tvalid_i <= 1'b0;

    fork
      drain();
      begin
        repeat (200000) @(posedge clk_i);
        n_err++;
      end
    join_any
    disable fork;

    if (n_err == 0) begin
      $display("iq_demodulator_phase_freq_tb: PASS");
    end else begin
      $display("iq_demodulator_phase_freq_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== iq_demodulator_phase_freq.f =====
hw/rtl/iqd_pkg.sv
hw/rtl/iqd_cordic_cell.sv
hw/rtl/iqd_cordic_chain.sv
hw/rtl/iq_demodulator_phase_freq.sv
tb/sv/iq_demodulator_phase_freq_tb.sv
